[hw/rtl/mrdp_pkg.sv]
// ----------------------------------------------------------------------------
// mrdp_pkg
// Shared types and constants of the marker displacement patcher.
// ----------------------------------------------------------------------------
package mrdp_pkg;

    // bytes held back while a marker may still be forming
    localparam int WIN_DEPTH  = 8;

    // command queue between matcher and serialiser
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDTH_CODE = 2'd0;
    localparam t_cfg_idx CFG_MARKER     = 2'd1;
    localparam t_cfg_idx CFG_TARGET     = 2'd2;

    // One command: a run of 1..8 output bytes. The first rep_n bytes come
    // from the displacement, the rest from the window snapshot.
    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] bytes;
        logic [63:0]               disp;
        logic [2:0]                end_idx;   // index of the final byte of the run
        logic [3:0]                rep_n;     // replaced byte count, 0 or marker length
        logic                      last;      // run closes the buffer
    } t_cmd;

endpackage

[hw/rtl/mrdp_front.sv]
// ----------------------------------------------------------------------------
// mrdp_front
// Matcher: holds the pending byte window, takes input beats, decides hit,
// miss or flush and hands at most one byte-run command per cycle to the queue while it is not full.
// ----------------------------------------------------------------------------
module mrdp_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_width_code,
    input  logic [63:0]          i_marker,
    input  logic [31:0]          i_target,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    input  logic                 i_q_full,
    output logic                 o_push,
    output mrdp_pkg::t_cmd       o_cmd
);

    logic [mrdp_pkg::WIN_DEPTH-1:0][7:0] r_win;
    logic [3:0]                          r_cnt;
    logic [OFFSET_BITS-1:0]              r_pos;
    logic                                r_iter;   // window still needs a step
    logic                                r_flush;  // last beat seen, flush owed

    logic                                accept;
    logic                                go;
    logic [3:0]                          len;
    logic [mrdp_pkg::WIN_DEPTH-1:0][7:0] w;
    logic [3:0]                          wcnt;
    logic                                wlast;
    logic                                iter;
    logic                                hit_ok;
    logic                                hit;
    logic [3:0]                          drop;
    logic [3:0]                          rem;
    logic                                flush;
    logic [mrdp_pkg::WIN_DEPTH-1:0][7:0] n_win;

    assign len        = 4'd1 << i_width_code;
    assign o_in_ready = !r_iter && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign go         = accept || (r_iter && !i_q_full);

    // working window: stored bytes plus the incoming beat
    always_comb begin
        for (int i = 0; i < mrdp_pkg::WIN_DEPTH; i++) begin
            w[i] = (accept && (r_cnt[2:0] == 3'(i))) ? i_data_byte : r_win[i];
        end
    end

    assign wcnt  = accept ? (r_cnt + 4'd1) : r_cnt;
    assign wlast = accept ? i_last : r_flush;
    assign iter  = (wcnt >= len);

    // compare the front of the window against the marker
    always_comb begin
        hit_ok = 1'b1;
        for (int i = 0; i < mrdp_pkg::WIN_DEPTH; i++) begin
            if ((4'(i) < len) && (w[i] != i_marker[8*i +: 8])) begin
                hit_ok = 1'b0;
            end
        end
    end

    assign hit   = iter && hit_ok;
    assign drop  = !iter ? 4'd0 : (hit ? len : 4'd1);
    assign rem   = wcnt - drop;
    assign flush = wlast && (rem < len);

    // drop the consumed bytes from the front
    always_comb begin
        if (!iter) begin
            n_win = w;
        end else if (!hit) begin
            n_win = w >> 8;
        end else begin
            case (i_width_code)
                2'd0:    n_win = w >> 8;
                2'd1:    n_win = w >> 16;
                2'd2:    n_win = w >> 32;
                default: n_win = '0;
            endcase
        end
    end

    // command towards the serialiser
    always_comb begin
        o_push        = go && (iter || flush);
        o_cmd.bytes   = w;
        o_cmd.disp    = 64'(i_target) - (64'(r_pos) + 64'(len));
        o_cmd.end_idx = flush ? 3'(wcnt - 4'd1) : 3'(drop - 4'd1);
        o_cmd.rep_n   = hit ? len : 4'd0;
        o_cmd.last    = flush;
    end

    // window control and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_pos   <= '0;
            r_iter  <= 1'b0;
            r_flush <= 1'b0;
        end else if (go) begin
            r_cnt   <= flush ? 4'd0 : rem;
            r_pos   <= flush ? '0 : (r_pos + OFFSET_BITS'(drop));
            r_iter  <= !flush && (rem >= len);
            r_flush <= wlast && !flush;
        end
    end

    // window bytes
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_win <= n_win;
        end
    end

endmodule

[hw/rtl/mrdp_cmdq.sv]
// ----------------------------------------------------------------------------
// mrdp_cmdq
// Short command FIFO decoupling the matcher from the byte serialiser.
// ----------------------------------------------------------------------------
module mrdp_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrdp_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output mrdp_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    localparam int CW = mrdp_pkg::CMDQ_AW + 1;

    mrdp_pkg::t_cmd                  r_mem [mrdp_pkg::CMDQ_DEPTH];
    logic [mrdp_pkg::CMDQ_AW-1:0]    r_wp;
    logic [mrdp_pkg::CMDQ_AW-1:0]    r_rp;
    logic [CW-1:0]                   r_cnt;
    logic                            push_ok;
    logic                            pop_ok;

    assign o_full  = (r_cnt == CW'(mrdp_pkg::CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[hw/rtl/mrdp_back.sv]
// ----------------------------------------------------------------------------
// mrdp_back
// Serialiser: unpacks each command into single output beats, substituting
// displacement bytes, behind a registered output stage.
// ----------------------------------------------------------------------------
module mrdp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mrdp_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last,
    output logic           o_replaced
);

    logic                                r_bv;
    logic [mrdp_pkg::WIN_DEPTH-1:0][7:0] r_buf;
    logic [2:0]                          r_idx;
    logic [2:0]                          r_end;
    logic [3:0]                          r_rep;
    logic                                r_last;

    logic                                r_ovalid;
    logic [7:0]                          r_obyte;
    logic                                r_olast;
    logic                                r_orep;

    logic                                out_load;
    logic                                buf_done;
    logic [mrdp_pkg::WIN_DEPTH-1:0][7:0] ld;

    assign out_load = r_bv && (!r_ovalid || i_out_ready);
    assign buf_done = out_load && (r_idx == r_end);
    assign o_q_pop  = i_q_valid && (!r_bv || buf_done);

    // displacement bytes replace the front of the run
    always_comb begin
        for (int i = 0; i < mrdp_pkg::WIN_DEPTH; i++) begin
            ld[i] = (4'(i) < i_q_cmd.rep_n) ? i_q_cmd.disp[8*i +: 8] : i_q_cmd.bytes[i];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_bv <= 1'b1;
            end else if (buf_done) begin
                r_bv <= 1'b0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // run buffer: load a command or shift one byte out
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_buf  <= ld;
            r_idx  <= '0;
            r_end  <= i_q_cmd.end_idx;
            r_rep  <= i_q_cmd.rep_n;
            r_last <= i_q_cmd.last;
        end else if (out_load) begin
            r_buf  <= r_buf >> 8;
            r_idx  <= r_idx + 1'b1;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte <= r_buf[0];
            r_orep  <= ({1'b0, r_idx} < r_rep);
            r_olast <= r_last && (r_idx == r_end);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;
    assign o_replaced  = r_orep;

endmodule

[hw/rtl/marker_relative_displacement_patch_top.sv]
// ----------------------------------------------------------------------------
// marker_relative_displacement_patch_top
// Finds copies of a 1/2/4/8 byte marker in a byte stream and overwrites each
// with the little-endian displacement to a configured target offset.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_data_byte, i_last
// output    out        o_out_valid / i_out_ready  o_out_byte, o_out_last, o_replaced
// config    in         i_cfg_we (write only)      i_cfg_idx, i_cfg_wdata
//
// One input beat per cycle sustained, one output beat per cycle, while the output
// is not stalled; the serialiser's single output port sets that figure. After a
// marker width change the window may need further steps, with input ready low.
// A completed run's command passes the queue entry, run buffer and output register
// before output valid rises. Synchronous active-low reset; no clearing pass. A
// four-entry command queue lets the matcher keep taking beats while the output
// side is stalled; input ready drops when that queue is full or a window step is owed.
// ----------------------------------------------------------------------------
module marker_relative_displacement_patch_top #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  mrdp_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [63:0]          i_cfg_wdata,
    // input stream
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    // output stream
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic                 o_replaced
);

    logic [1:0]     r_width_code;
    logic [63:0]    r_marker;
    logic [31:0]    r_target;

    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    mrdp_pkg::t_cmd f_cmd;
    mrdp_pkg::t_cmd q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_code <= 2'd2;
            r_marker     <= '0;
            r_target     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrdp_pkg::CFG_WIDTH_CODE: r_width_code <= i_cfg_wdata[1:0];
                mrdp_pkg::CFG_MARKER:     r_marker     <= i_cfg_wdata;
                mrdp_pkg::CFG_TARGET:     r_target     <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // matcher
    mrdp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width_code (r_width_code),
        .i_marker     (r_marker),
        .i_target     (r_target),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (f_cmd)
    );

    // command queue
    mrdp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // serialiser
    mrdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_replaced  (o_replaced)
    );

endmodule
